// ===== rtl/kpe_pkg.sv =====
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types, key ids, codes and the routing table of the keypad scanner.
// ----------------------------------------------------------------------------
`default_nettype none
package kpe_pkg;

   localparam int NUM_LANES = 21;   // 20 matrix positions plus the volume key
   localparam int NUM_KEYS  = 20;

   localparam logic [4:0] ID_ZIN   = 5'd4;
   localparam logic [4:0] ID_ZOUT  = 5'd9;
   localparam logic [4:0] ID_CD    = 5'd11;
   localparam logic [4:0] ID_AMFM  = 5'd16;
   localparam logic [4:0] ID_GAP   = 5'd18;
   localparam logic [4:0] ID_VOL   = 5'd20;
   localparam logic [4:0] ID_CHORD = 5'd21;

   localparam logic [15:0] CHORD_WINDOW = 16'd500;

   // key phase codes
   localparam logic [1:0] PH_REL = 2'd0;
   localparam logic [1:0] PH_PRS = 2'd1;
   localparam logic [1:0] PH_HLD = 2'd2;

   // event result codes
   localparam logic [1:0] RES_PRESSED  = 2'd0;
   localparam logic [1:0] RES_RELEASED = 2'd1;
   localparam logic [1:0] RES_HELD     = 2'd2;

   // register indexes
   localparam logic [2:0] REG_DFLT_ADDR   = 3'd0;
   localparam logic [2:0] REG_AUDIO_ADDR  = 3'd1;
   localparam logic [2:0] REG_SRC_ADDR    = 3'd2;
   localparam logic [2:0] REG_COMPUTER_ID = 3'd3;
   localparam logic [2:0] REG_RADIO_ID    = 3'd4;
   localparam logic [2:0] REG_COMPUTER_UP = 3'd5;
   localparam logic [2:0] REG_RADIO_UP    = 3'd6;
   localparam logic [2:0] REG_HOLD_MS     = 3'd7;

   typedef enum logic [1:0] {
      ROUTE_ALL    = 2'd0,
      ROUTE_AUDIO  = 2'd1,
      ROUTE_SOURCE = 2'd2
   } route_type;

   typedef struct packed {
      logic [7:0] dflt_addr;
      logic [7:0] audio_addr;
      logic [7:0] src_addr;
      logic [7:0] computer_id;
      logic [7:0] radio_id;
      logic       computer_up;
      logic       radio_up;
   } cfg_type;

   // events found by the lanes for one scan
   typedef struct packed {
      logic [NUM_LANES-1:0] press_pend;
      logic [NUM_LANES-1:0] press_rel;
      logic [NUM_LANES-1:0] hold_pend;
      logic                 chord_en;
      logic                 chord_at_amfm;
   } scan_events_type;

   // routing class of a key id
   function automatic route_type route_of(input logic [4:0] id);
      route_type r;
      r = ROUTE_ALL;
      unique case (id)
         5'd1, 5'd2, 5'd3, 5'd7, 5'd8, 5'd12, 5'd13, 5'd14, 5'd17, 5'd19:
            r = ROUTE_SOURCE;
         5'd11, 5'd16, 5'd20, 5'd21:
            r = ROUTE_AUDIO;
         default:
            r = ROUTE_ALL;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/kpe_if.sv =====
// ----------------------------------------------------------------------------
// kpe_req_if / kpe_rsp_if
// Valid/ready channels for scan requests and event results.
// ----------------------------------------------------------------------------
`default_nettype none
interface kpe_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] key_bits;
   logic        vol_down;
   logic        vol_present;
   logic [15:0] elapsed_ms;

   modport source (output valid, key_bits, vol_down, vol_present, elapsed_ms,
                   input ready);
   modport sink   (input valid, key_bits, vol_down, vol_present, elapsed_ms,
                   output ready);
endinterface

interface kpe_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [4:0] key_id;
   logic [1:0] event_res;
   logic       zoom_in;
   logic [7:0] dest;
   logic       ack;
   logic       last;

   modport source (output valid, kind, key_id, event_res, zoom_in, dest, ack, last,
                   input ready);
   modport sink   (input valid, kind, key_id, event_res, zoom_in, dest, ack, last,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/kpe_lane.sv =====
// ----------------------------------------------------------------------------
// kpe_lane
// One key lane: timer advance with saturation, press/release decision and
// hold qualification on the post-press state.
// ----------------------------------------------------------------------------
`default_nettype none
module kpe_lane
   import kpe_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                  down,
   input  wire logic                  scan_en,
   input  wire logic                  is_zoom,
   input  wire logic                  latch_on,
   input  wire logic [1:0]            phase_cur,
   input  wire logic [TIMER_BITS-1:0] age_cur,
   input  wire logic [15:0]           elapsed_ms,
   input  wire logic [15:0]           hold_ms,
   output logic      [1:0]            phase_post,
   output logic      [TIMER_BITS-1:0] age_post,
   output logic                       ev,
   output logic                       ev_rel,
   output logic                       latch_clr,
   output logic                       hold_ok
);
   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam int SW = CW + 1;

   logic [SW-1:0]         sum;
   logic [TIMER_BITS-1:0] age_sat;

   // advance the timer, saturate at all ones
   always_comb begin
      sum = SW'(age_cur) + SW'(elapsed_ms);
      if (sum[SW-1:TIMER_BITS] != '0) begin
         age_sat = '1;
      end else begin
         age_sat = sum[TIMER_BITS-1:0];
      end
   end

   // press pass decision
   always_comb begin
      phase_post = phase_cur;
      age_post   = age_sat;
      ev         = 1'b0;
      ev_rel     = 1'b0;
      latch_clr  = 1'b0;
      if (scan_en) begin
         if (is_zoom) begin
            if (down && phase_cur == PH_REL) begin
               ev         = 1'b1;
               phase_post = PH_PRS;
            end else if (!down && phase_cur != PH_REL) begin
               phase_post = PH_REL;
            end
         end else if (latch_on) begin
            if (!down) begin
               latch_clr  = 1'b1;
               phase_post = PH_REL;
            end
         end else if (down && phase_cur == PH_REL) begin
            age_post   = '0;
            phase_post = PH_PRS;
            ev         = 1'b1;
         end else if (!down && phase_cur != PH_REL) begin
            phase_post = PH_REL;
            ev         = 1'b1;
            ev_rel     = 1'b1;
         end
      end
   end

   // hold qualification
   assign hold_ok = !is_zoom && (phase_post == PH_PRS) &&
                    (CW'(age_post) >= CW'(hold_ms));

endmodule
`default_nettype wire

// ===== rtl/kpe_merge.sv =====
// ----------------------------------------------------------------------------
// kpe_merge
// Merge the lane results into one ordered event stream: press events by id,
// then hold events by id, the chord taking the place of its hold slot.
// ----------------------------------------------------------------------------
`default_nettype none
module kpe_merge
   import kpe_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire scan_events_type load_events,
   input  wire cfg_type         cfg,
   output logic                 idle,
   kpe_rsp_if.source            rsp
);
   localparam int NP = 2 * NUM_LANES;

   logic [NP-1:0]        pend_ff, pend_in;
   logic [NUM_LANES-1:0] rel_ff;
   logic                 chord_en_ff;
   logic                 chord_amfm_ff;
   logic                 half_ff, half_in;

   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [4:0] id_ff, id_in;
   logic [1:0] res_ff, res_in;
   logic       zin_ff, zin_in;
   logic [7:0] dest_ff, dest_in;
   logic       ack_ff, ack_in;
   logic       last_ff, last_in;

   logic [5:0]    pick;
   logic          found;
   logic [NP-1:0] pick_hot;
   logic          is_hold;
   logic [4:0]    lane;
   logic          chord_slot;
   logic          out_free;
   logic          emit;
   logic          clear_bit;
   logic [NP-1:0] rest;

   // lowest pending slot first
   always_comb begin
      pick  = '0;
      found = 1'b0;
      for (int i = NP - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick  = 6'(i);
            found = 1'b1;
         end
      end
      for (int i = 0; i < NP; i++) begin
         pick_hot[i] = found && (pick == 6'(i));
      end
   end

   assign is_hold    = (pick >= 6'(NUM_LANES));
   assign lane       = is_hold ? 5'(pick - 6'(NUM_LANES)) : pick[4:0];
   assign chord_slot = chord_en_ff && is_hold &&
                       (lane == (chord_amfm_ff ? ID_AMFM : ID_CD));
   assign out_free   = !valid_ff || rsp.ready;
   assign emit       = found && out_free;
   assign clear_bit  = !chord_slot || half_ff;
   assign rest       = pend_ff & ~pick_hot;
   assign idle       = !found;

   // build the next event
   always_comb begin
      route_type rt;
      kind_in = 1'b0;
      id_in   = lane;
      res_in  = RES_PRESSED;
      zin_in  = 1'b0;
      if (chord_slot) begin
         id_in  = ID_CHORD;
         res_in = half_ff ? RES_RELEASED : RES_PRESSED;
      end else if (is_hold) begin
         res_in = RES_HELD;
      end else if (lane == ID_ZIN || lane == ID_ZOUT) begin
         kind_in = 1'b1;
         zin_in  = (lane == ID_ZIN);
      end else begin
         res_in = rel_ff[lane] ? RES_RELEASED : RES_PRESSED;
      end
      rt = route_of(id_in);
      unique case (rt)
         ROUTE_AUDIO:  dest_in = cfg.audio_addr;
         ROUTE_SOURCE: dest_in = cfg.src_addr;
         default:      dest_in = cfg.dflt_addr;
      endcase
      if (dest_in == cfg.computer_id && !cfg.computer_up) begin
         ack_in = 1'b0;
      end else if (dest_in == cfg.radio_id && !cfg.radio_up) begin
         ack_in = 1'b0;
      end else begin
         ack_in = 1'b1;
      end
      last_in = clear_bit && (rest == '0);
   end

   // pending slots and chord half
   always_comb begin
      pend_in = pend_ff;
      half_in = half_ff;
      if (load) begin
         pend_in = {load_events.hold_pend, load_events.press_pend};
         half_in = 1'b0;
      end else if (emit) begin
         if (clear_bit) begin
            pend_in = rest;
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end
      valid_in = emit ? 1'b1 : (out_free ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         half_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         half_ff  <= half_in;
         valid_ff <= valid_in;
      end
   end

   // hold scan info and the output payload
   always_ff @(posedge clock) begin
      if (load) begin
         rel_ff        <= load_events.press_rel;
         chord_en_ff   <= load_events.chord_en;
         chord_amfm_ff <= load_events.chord_at_amfm;
      end
      if (emit) begin
         kind_ff <= kind_in;
         id_ff   <= id_in;
         res_ff  <= res_in;
         zin_ff  <= zin_in;
         dest_ff <= dest_in;
         ack_ff  <= ack_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.kind      = kind_ff;
   assign rsp.key_id    = id_ff;
   assign rsp.event_res = res_ff;
   assign rsp.zoom_in   = zin_ff;
   assign rsp.dest      = dest_ff;
   assign rsp.ack       = ack_ff;
   assign rsp.last      = last_ff;

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> idle)
      else $error("scan loaded while events pending");

   a_half_pending: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (pend_ff != '0))
      else $error("chord half set with nothing pending");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (emit && last_in) |=> (pend_ff == '0))
      else $error("last event emitted but slots remain");

endmodule
`default_nettype wire

// ===== rtl/keypad_press_hold_event_scanner_top.sv =====
// An accepted scan loads the merger's pending slots, and each event then leaves
// through the merger's output register. The serial merger emits one event per
// cycle while the receiver is ready, and at most 38 events for one scan.
// A new scan is taken once the merger has no pending slots left.
// Reset (synchronous, active high): all keys released, timers and latches zero,
// registers zero except hold_ms = 1000.
// ----------------------------------------------------------------------------
// keypad_press_hold_event_scanner_top
// Key matrix press/release/hold event scanner with per-key lanes.
// ----------------------------------------------------------------------------
`default_nettype none
module keypad_press_hold_event_scanner_top
   import kpe_pkg::*;
#(
   parameter int TIMER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   kpe_req_if.sink          req_chan,
   kpe_rsp_if.source        rsp_chan
);
   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   cfg_type     cfg_ff;
   logic [15:0] hold_ff;

   logic [1:0]            phase_ff [NUM_LANES];
   logic [1:0]            phase_in [NUM_LANES];
   logic [TIMER_BITS-1:0] age_ff   [NUM_LANES];
   logic [TIMER_BITS-1:0] age_post [NUM_LANES];
   logic [1:0]            phase_post [NUM_LANES];
   logic                  amfm_latch_ff, amfm_latch_in;
   logic                  cd_latch_ff, cd_latch_in;

   logic [NUM_LANES-1:0] ev, ev_rel, latch_clr, hold_ok;
   logic [NUM_LANES-1:0] hold_eff;
   logic                 accept;
   logic                 idle;
   logic [TIMER_BITS-1:0] diff;
   logic                 chord;
   scan_events_type      events;

   assign req_chan.ready = idle;
   assign accept         = req_chan.valid && idle;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         hold_ff <= 16'd1000;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DFLT_ADDR:   cfg_ff.dflt_addr   <= csr_wdata[7:0];
            REG_AUDIO_ADDR:  cfg_ff.audio_addr  <= csr_wdata[7:0];
            REG_SRC_ADDR:    cfg_ff.src_addr    <= csr_wdata[7:0];
            REG_COMPUTER_ID: cfg_ff.computer_id <= csr_wdata[7:0];
            REG_RADIO_ID:    cfg_ff.radio_id    <= csr_wdata[7:0];
            REG_COMPUTER_UP: cfg_ff.computer_up <= csr_wdata[0];
            REG_RADIO_UP:    cfg_ff.radio_up    <= csr_wdata[0];
            REG_HOLD_MS:     hold_ff            <= csr_wdata;
            default:         hold_ff            <= hold_ff;
         endcase
      end
   end

   // key lanes, volume in the last lane
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      localparam bit IS_VOL  = (k == NUM_KEYS);
      localparam bit IS_ZOOM = (k == int'(ID_ZIN)) || (k == int'(ID_ZOUT));
      localparam bit IS_GAP  = (k == int'(ID_GAP));
      logic down, scan_en, latch_on;
      if (IS_VOL) begin : g_vol
         assign down    = req_chan.vol_down;
         assign scan_en = req_chan.vol_present;
      end else begin : g_key
         assign down    = req_chan.key_bits[k];
         assign scan_en = !IS_GAP;
      end
      if (k == int'(ID_AMFM)) begin : g_amfm
         assign latch_on = amfm_latch_ff;
      end else if (k == int'(ID_CD)) begin : g_cd
         assign latch_on = cd_latch_ff;
      end else begin : g_nolatch
         assign latch_on = 1'b0;
      end
      kpe_lane #(.TIMER_BITS(TIMER_BITS)) u_lane (
         .down       (down),
         .scan_en    (scan_en),
         .is_zoom    (IS_ZOOM),
         .latch_on   (latch_on),
         .phase_cur  (phase_ff[k]),
         .age_cur    (age_ff[k]),
         .elapsed_ms (req_chan.elapsed_ms),
         .hold_ms    (hold_ff),
         .phase_post (phase_post[k]),
         .age_post   (age_post[k]),
         .ev         (ev[k]),
         .ev_rel     (ev_rel[k]),
         .latch_clr  (latch_clr[k]),
         .hold_ok    (hold_ok[k])
      );
   end

   // chord check between AM/FM and CD
   always_comb begin
      if (age_post[ID_AMFM] > age_post[ID_CD]) begin
         diff = age_post[ID_AMFM] - age_post[ID_CD];
      end else begin
         diff = age_post[ID_CD] - age_post[ID_AMFM];
      end
      chord = (phase_post[ID_AMFM] == PH_PRS) && (phase_post[ID_CD] == PH_PRS) &&
              (CW'(diff) <= CW'(CHORD_WINDOW)) && (hold_ok[ID_CD] || hold_ok[ID_AMFM]);
   end

   // merge lane findings into events and next state
   always_comb begin
      hold_eff         = hold_ok;
      hold_eff[ID_GAP] = 1'b0;
      if (chord) begin
         hold_eff[ID_CD]   = 1'b0;
         hold_eff[ID_AMFM] = 1'b0;
      end
      events.press_pend    = ev;
      events.press_rel     = ev_rel;
      events.hold_pend     = hold_eff;
      events.chord_en      = chord;
      events.chord_at_amfm = !hold_ok[ID_CD];
      if (chord) begin
         if (hold_ok[ID_CD]) begin
            events.hold_pend[ID_CD] = 1'b1;
         end else begin
            events.hold_pend[ID_AMFM] = 1'b1;
         end
      end
      for (int k = 0; k < NUM_LANES; k++) begin
         phase_in[k] = hold_eff[k] ? PH_HLD : phase_post[k];
      end
      if (chord) begin
         phase_in[ID_CD]   = PH_HLD;
         phase_in[ID_AMFM] = PH_HLD;
      end
      amfm_latch_in = chord || (amfm_latch_ff && !latch_clr[ID_AMFM]);
      cd_latch_in   = chord || (cd_latch_ff && !latch_clr[ID_CD]);
   end

   // key state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LANES; k++) begin
            phase_ff[k] <= PH_REL;
            age_ff[k]   <= '0;
         end
         amfm_latch_ff <= 1'b0;
         cd_latch_ff   <= 1'b0;
      end else if (accept) begin
         for (int k = 0; k < NUM_LANES; k++) begin
            phase_ff[k] <= phase_in[k];
            age_ff[k]   <= age_post[k];
         end
         amfm_latch_ff <= amfm_latch_in;
         cd_latch_ff   <= cd_latch_in;
      end
   end

   kpe_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .load_events (events),
      .cfg         (cfg_ff),
      .idle        (idle),
      .rsp         (rsp_chan)
   );

   a_latches_together: assert property (@(posedge clock) disable iff (reset)
      (accept && chord) |=> (amfm_latch_ff && cd_latch_ff))
      else $error("chord did not set both latches");

   a_chord_phases: assert property (@(posedge clock) disable iff (reset)
      (accept && chord) |=> (phase_ff[ID_AMFM] == PH_HLD && phase_ff[ID_CD] == PH_HLD))
      else $error("chord keys not held");

   a_gap_quiet: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!ev[ID_GAP] && !hold_eff[ID_GAP]))
      else $error("absent position produced an event");

endmodule
`default_nettype wire

// ===== dv/keypad_press_hold_event_scanner_top_tb.sv =====
// ----------------------------------------------------------------------------
// keypad_press_hold_event_scanner_top_tb
// Drives key matrix scans into the event scanner and checks every press,
// release, hold, zoom and chord event against a scoreboard model of the
// key timers and phases, under random idling, back-pressure and register
// settings.
// ----------------------------------------------------------------------------
module keypad_press_hold_event_scanner_top_tb
   import kpe_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [19:0] key_bits;
      logic        vol_down;
      logic        vol_present;
      logic [15:0] elapsed_ms;
   } scan_type;

   typedef struct packed {
      logic       kind;
      logic [4:0] key_id;
      logic [1:0] event_res;
      logic       zoom_in;
      logic [7:0] dest;
      logic       ack;
      logic       last;
   } key_event_type;

   // directed row: scan plus an optional typed-in first event
   typedef struct packed {
      scan_type      scan;
      logic          typed;
      key_event_type first_evt;
   } scan_row_type;

   localparam logic [15:0] AGE_MAX = 16'hFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   kpe_req_if req_chan ();
   kpe_rsp_if rsp_chan ();

   keypad_press_hold_event_scanner_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // model state
   logic [1:0]  key_phase [NUM_KEYS];
   logic [15:0] key_age [NUM_KEYS];
   logic [1:0]  vol_phase;
   logic [15:0] vol_age;
   logic        amfm_latch, cd_latch;
   logic [7:0]  dflt_addr, audio_addr, src_addr, computer_id, radio_id;
   logic        computer_up, radio_up;
   logic [15:0] hold_ms;

   key_event_type pending_events [$];
   key_event_type new_events [$];
   int   fail_count = 0;
   bit   hold_off = 1'b0;
   int   hold_cycles = 0;

   task automatic report(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic logic [15:0] age_sum(input logic [15:0] a, input logic [15:0] e);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, e};
      return s[16] ? AGE_MAX : s[15:0];
   endfunction

   function automatic logic [7:0] dest_of(input logic [4:0] id);
      logic [7:0] d;
      d = dflt_addr;
      if (id == 5'd11 || id == 5'd16 || id == 5'd20 || id == 5'd21)
         d = audio_addr;
      else if (id inside {5'd1, 5'd2, 5'd3, 5'd7, 5'd8, 5'd12, 5'd13, 5'd14, 5'd17,
                          5'd19})
         d = src_addr;
      return d;
   endfunction

   function automatic void add_event(input logic k, input logic [4:0] id,
                                     input logic [1:0] res, input logic zin);
      key_event_type e;
      e.kind = k;
      e.key_id = id;
      e.event_res = res;
      e.zoom_in = zin;
      e.dest = dest_of(id);
      e.ack = 1'b1;
      if (e.dest == computer_id && !computer_up) e.ack = 1'b0;
      else if (e.dest == radio_id && !radio_up) e.ack = 1'b0;
      e.last = 1'b0;
      new_events.push_back(e);
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < NUM_KEYS; i++) begin
         key_phase[i] = PH_REL;
         key_age[i] = '0;
      end
      vol_phase = PH_REL;
      vol_age = '0;
      amfm_latch = 1'b0;
      cd_latch = 1'b0;
      {dflt_addr, audio_addr, src_addr, computer_id, radio_id} = '0;
      computer_up = 1'b0;
      radio_up = 1'b0;
      hold_ms = 16'd1000;
   endfunction

   // compute events of one scan and queue them
   function automatic void predict_scan(input scan_type s);
      logic        down;
      logic [15:0] a, c, d;
      bit          chord;
      logic [4:0]  kid;
      new_events.delete();
      for (int i = 0; i < NUM_KEYS; i++) key_age[i] = age_sum(key_age[i], s.elapsed_ms);
      vol_age = age_sum(vol_age, s.elapsed_ms);

      // press pass
      for (int i = 0; i < NUM_KEYS; i++) begin
         kid = 5'(i);
         down = s.key_bits[i];
         if (kid == ID_GAP) continue;
         if (kid == ID_ZIN || kid == ID_ZOUT) begin
            if (down && key_phase[i] == PH_REL) begin
               add_event(1'b1, kid, RES_PRESSED, kid == ID_ZIN);
               key_phase[i] = PH_PRS;
            end else if (!down && key_phase[i] != PH_REL) begin
               key_phase[i] = PH_REL;
            end
            continue;
         end
         if ((kid == ID_AMFM && amfm_latch) || (kid == ID_CD && cd_latch)) begin
            if (!down) begin
               if (kid == ID_AMFM) amfm_latch = 1'b0;
               else cd_latch = 1'b0;
               key_phase[i] = PH_REL;
            end
            continue;
         end
         if (down && key_phase[i] == PH_REL) begin
            key_age[i] = '0;
            key_phase[i] = PH_PRS;
            add_event(1'b0, kid, RES_PRESSED, 1'b0);
         end else if (!down && key_phase[i] != PH_REL) begin
            key_phase[i] = PH_REL;
            add_event(1'b0, kid, RES_RELEASED, 1'b0);
         end
      end
      if (s.vol_present) begin
         if (s.vol_down && vol_phase == PH_REL) begin
            vol_age = '0;
            vol_phase = PH_PRS;
            add_event(1'b0, ID_VOL, RES_PRESSED, 1'b0);
         end else if (!s.vol_down && vol_phase != PH_REL) begin
            vol_phase = PH_REL;
            add_event(1'b0, ID_VOL, RES_RELEASED, 1'b0);
         end
      end

      // hold pass, chord replaces held events of AM/FM and CD
      for (int i = 0; i < NUM_KEYS; i++) begin
         kid = 5'(i);
         if (kid == ID_GAP || kid == ID_ZIN || kid == ID_ZOUT) continue;
         if (key_phase[i] != PH_PRS || key_age[i] < hold_ms) continue;
         chord = 1'b0;
         if (kid == ID_AMFM || kid == ID_CD) begin
            a = key_age[ID_AMFM];
            c = key_age[ID_CD];
            d = a > c ? a - c : c - a;
            chord = key_phase[ID_AMFM] == PH_PRS && key_phase[ID_CD] == PH_PRS &&
                    d <= CHORD_WINDOW;
         end
         if (chord) begin
            amfm_latch = 1'b1;
            cd_latch = 1'b1;
            key_phase[ID_AMFM] = PH_HLD;
            key_phase[ID_CD] = PH_HLD;
            add_event(1'b0, ID_CHORD, RES_PRESSED, 1'b0);
            add_event(1'b0, ID_CHORD, RES_RELEASED, 1'b0);
         end else begin
            key_phase[i] = PH_HLD;
            add_event(1'b0, kid, RES_HELD, 1'b0);
         end
      end
      if (vol_phase == PH_PRS && vol_age >= hold_ms) begin
         vol_phase = PH_HLD;
         add_event(1'b0, ID_VOL, RES_HELD, 1'b0);
      end

      if (new_events.size() > 0) new_events[new_events.size()-1].last = 1'b1;
      foreach (new_events[i]) pending_events.push_back(new_events[i]);
   endfunction

   // write one register, then update the model copy
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_DFLT_ADDR:   dflt_addr = val[7:0];
         REG_AUDIO_ADDR:  audio_addr = val[7:0];
         REG_SRC_ADDR:    src_addr = val[7:0];
         REG_COMPUTER_ID: computer_id = val[7:0];
         REG_RADIO_ID:    radio_id = val[7:0];
         REG_COMPUTER_UP: computer_up = val[0];
         REG_RADIO_UP:    radio_up = val[0];
         REG_HOLD_MS:     hold_ms = val;
         default: ;
      endcase
   endtask

   task automatic wait_drain();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      while (pending_events.size() > 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (50) @(posedge clock);
   endtask

   // send one scan request, with a random gap before it when gaps is set
   task automatic send_scan(input scan_type s, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 8) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.key_bits    <= s.key_bits;
      req_chan.vol_down    <= s.vol_down;
      req_chan.vol_present <= s.vol_present;
      req_chan.elapsed_ms  <= s.elapsed_ms;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_scan(s);
   endtask

   function automatic scan_type mk(input logic [19:0] kb, input logic vd,
                                   input logic vp, input logic [15:0] el);
      scan_type s;
      s = '{kb, vd, vp, el};
      return s;
   endfunction

   function automatic key_event_type ev(input logic k, input logic [4:0] id,
                                        input logic [1:0] res, input logic zin,
                                        input logic [7:0] dst, input logic ak,
                                        input logic lst);
      key_event_type e;
      e = '{k, id, res, zin, dst, ak, lst};
      return e;
   endfunction

   // random scan: mostly small changes of a held key set
   function automatic scan_type random_scan(input scan_type prev);
      scan_type s;
      s = prev;
      case ($urandom_range(0, 9))
         0: s.key_bits = 20'($urandom);
         1: s.key_bits = '0;
         2: s.key_bits = (1 << 11) | (1 << 16);
         default: s.key_bits = prev.key_bits ^ (20'd1 << $urandom_range(0, 19));
      endcase
      if ($urandom_range(0, 3) == 0) s.vol_down = ~prev.vol_down;
      s.vol_present = $urandom_range(0, 5) != 0;
      case ($urandom_range(0, 5))
         0: s.elapsed_ms = 16'($urandom);
         1: s.elapsed_ms = 16'hFFFF;
         2: s.elapsed_ms = 16'd0;
         default: s.elapsed_ms = 16'($urandom_range(0, 600));
      endcase
      return s;
   endfunction

   // result sink: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_off) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         hold_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // compare each accepted event with the oldest expectation
   always @(posedge clock) begin
      key_event_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.kind, rsp_chan.key_id, rsp_chan.event_res, rsp_chan.zoom_in,
                 rsp_chan.dest, rsp_chan.ack, rsp_chan.last};
         if (pending_events.size() == 0) begin
            report($sformatf("unexpected event %p", got));
         end else begin
            want = pending_events.pop_front();
            if (got.kind != want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.key_id != want.key_id)
               report($sformatf("key_id %0d want %0d", got.key_id, want.key_id));
            if (got.event_res != want.event_res)
               report($sformatf("event_res %0d want %0d (key %0d)", got.event_res,
                                want.event_res, want.key_id));
            if (got.zoom_in != want.zoom_in) report("zoom_in differs");
            if (got.dest != want.dest)
               report($sformatf("dest %0h want %0h (key %0d)", got.dest, want.dest,
                                want.key_id));
            if (got.ack != want.ack) report($sformatf("ack on key %0d", want.key_id));
            if (got.last != want.last) report($sformatf("last on key %0d", want.key_id));
         end
      end
   end

   initial begin
      scan_row_type rows [$];
      scan_type     cur;
      logic [15:0]  settings [4][8];

      req_chan.valid = 1'b0;
      req_chan.key_bits = '0;
      req_chan.vol_down = 1'b0;
      req_chan.vol_present = 1'b0;
      req_chan.elapsed_ms = '0;
      clear_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // routing and ack setup: computer at the source address, radio at the audio one
      write_reg(REG_DFLT_ADDR, 16'h10);
      write_reg(REG_AUDIO_ADDR, 16'h40);
      write_reg(REG_SRC_ADDR, 16'h23);
      write_reg(REG_COMPUTER_ID, 16'h23);
      write_reg(REG_RADIO_ID, 16'h40);
      write_reg(REG_COMPUTER_UP, 16'h1);
      write_reg(REG_RADIO_UP, 16'h0);
      write_reg(REG_HOLD_MS, 16'd1000);

      // directed table
      rows.push_back('{mk(20'h00001, 0, 1, 0), 1, ev(0, 0, RES_PRESSED, 0, 8'h10, 1, 1)});
      rows.push_back('{mk(20'h00000, 0, 1, 5), 1, ev(0, 0, RES_RELEASED, 0, 8'h10, 1, 1)});
      rows.push_back('{mk(20'h00010, 0, 1, 0), 1, ev(1, 4, RES_PRESSED, 1, 8'h10, 1, 1)});
      rows.push_back('{mk(20'h00000, 0, 1, 0), 0, '0});
      rows.push_back('{mk(20'h00200, 0, 1, 0), 1, ev(1, 9, RES_PRESSED, 0, 8'h10, 1, 1)});
      rows.push_back('{mk(20'h00200, 0, 1, 16'hFFFF), 0, '0});
      rows.push_back('{mk(20'h00000, 1, 1, 0), 1, ev(0, 20, RES_PRESSED, 0, 8'h40, 0, 1)});
      rows.push_back('{mk(20'h00000, 1, 1, 16'hFFFF), 1, ev(0, 20, RES_HELD, 0, 8'h40, 0, 1)});
      rows.push_back('{mk(20'h00000, 0, 0, 0), 0, '0});
      rows.push_back('{mk(20'h00000, 0, 1, 0), 1, ev(0, 20, RES_RELEASED, 0, 8'h40, 0, 1)});
      rows.push_back('{mk(20'h00002, 0, 1, 0), 1, ev(0, 1, RES_PRESSED, 0, 8'h23, 1, 1)});
      rows.push_back('{mk(20'h00002, 0, 1, 1000), 1, ev(0, 1, RES_HELD, 0, 8'h23, 1, 1)});
      rows.push_back('{mk(20'h40000, 0, 1, 0), 0, '0});
      rows.push_back('{mk(20'hFFFFF, 1, 1, 0), 0, '0});
      rows.push_back('{mk(20'hFFFFF, 1, 1, 16'hFFFF), 0, '0});
      rows.push_back('{mk(20'h00000, 0, 1, 0), 0, '0});
      // chord: AM/FM and CD together, then within and outside the window
      rows.push_back('{mk(20'h10800, 0, 1, 0), 0, '0});
      rows.push_back('{mk(20'h10800, 0, 1, 1200), 1, ev(0, 21, RES_PRESSED, 0, 8'h40, 0, 0)});
      rows.push_back('{mk(20'h10800, 0, 1, 3000), 0, '0});
      rows.push_back('{mk(20'h00800, 0, 1, 0), 0, '0});
      rows.push_back('{mk(20'h00000, 0, 1, 0), 0, '0});
      rows.push_back('{mk(20'h00800, 0, 1, 0), 0, '0});
      rows.push_back('{mk(20'h10800, 0, 1, 600), 0, '0});
      rows.push_back('{mk(20'h10800, 0, 1, 1000), 0, '0});
      rows.push_back('{mk(20'h00000, 0, 1, 7), 0, '0});

      foreach (rows[i]) begin
         send_scan(rows[i].scan, 1'b0);
         if (rows[i].typed &&
             (new_events.size() == 0 || new_events[0] != rows[i].first_evt))
            report($sformatf("directed row %0d first event differs", i));
      end
      wait_drain();

      // hold_ms 0: a press is held in the same scan
      write_reg(REG_HOLD_MS, 16'd0);
      send_scan(mk(20'h00008, 0, 1, 0), 1'b0);
      send_scan(mk(20'h00000, 0, 1, 0), 1'b0);
      wait_drain();

      // register sets, extremes among them
      settings[0] = '{16'h00, 16'h00, 16'h00, 16'h00, 16'h00, 16'h0, 16'h0, 16'd0};
      settings[1] = '{16'hFF, 16'hFF, 16'hFF, 16'hFF, 16'hFF, 16'h1, 16'h1, 16'hFFFF};
      settings[2] = '{16'h10, 16'h40, 16'h23, 16'h10, 16'h23, 16'h0, 16'h1, 16'd300};
      settings[3] = '{16'h06, 16'h80, 16'h40, 16'h80, 16'h06, 16'h1, 16'h0, 16'd1000};

      cur = mk('0, 0, 1, 0);
      for (int p = 0; p < 4; p++) begin
         for (int r = 0; r < 8; r++) write_reg(3'(r), settings[p][r]);
         // long receiver hold-off while scans keep coming
         if (p == 2) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int k = 0; k < 75; k++) begin
            cur = random_scan(cur);
            send_scan(cur, 1'b1);
         end
         wait_drain();
      end

      if (pending_events.size() == 0 && fail_count == 0)
         $display("** keypad_press_hold_event_scanner_top: PASSED **");
      else
         $display("** keypad_press_hold_event_scanner_top: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** keypad_press_hold_event_scanner_top: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/kpe_pkg.sv
rtl/kpe_if.sv
rtl/kpe_lane.sv
rtl/kpe_merge.sv
rtl/keypad_press_hold_event_scanner_top.sv
dv/keypad_press_hold_event_scanner_top_tb.sv
